### rtl/core/wtra_pkg.sv
`timescale 1ns / 1ps

package wtra_pkg;

    // operation codes carried in tuser
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_ADD_MS  = 2'd1;
    localparam logic [1:0] OP_ADD_MIN = 2'd2;
    localparam logic [1:0] OP_HOLD    = 2'd3;

    // register indexes on the config port
    localparam logic CFG_TARGET = 1'b0;
    localparam logic CFG_MARGIN = 1'b1;

    localparam longint MS_PER_DAY   = 86400000;
    localparam longint MIN_PER_DAY  = 24 * 60;
    localparam longint MS_PER_MIN   = 60000;
    localparam longint MS_PER_SEC   = 1000;
    localparam longint MIN_PER_HOUR = 60;
    localparam longint HM_SCALE     = 100;
    localparam longint HM_GAP       = HM_SCALE - MIN_PER_HOUR;
    localparam longint DAYS_WEEK    = 7;
    localparam longint DAY_MAX      = DAYS_WEEK - 1;

    // amount is rebiased to unsigned: x = amount + 2^31 + bias, floor(amount/L) = x/L - (K+1)
    localparam longint AMT_HALF  = 64'sd2147483648;
    localparam longint KD_MS     = AMT_HALF / MS_PER_DAY;
    localparam longint KD_MIN    = AMT_HALF / MIN_PER_DAY;
    localparam longint BIAS_MS_L = MS_PER_DAY - (AMT_HALF - KD_MS * MS_PER_DAY);
    localparam longint BIAS_MN_L = MIN_PER_DAY - (AMT_HALF - KD_MIN * MIN_PER_DAY);

    localparam logic [32:0] BIAS_MS  = 33'(BIAS_MS_L);
    localparam logic [32:0] BIAS_MIN = 33'(BIAS_MN_L);
    localparam logic [3:0] DAY_BACK_MS  = 4'(DAYS_WEEK - ((KD_MS + 1) % DAYS_WEEK));
    localparam logic [3:0] DAY_BACK_MIN = 4'(DAYS_WEEK - ((KD_MIN + 1) % DAYS_WEEK));

    // reciprocal estimates (low side) for the day split
    localparam int XSH_MS  = 20;
    localparam int QSH_MS  = 20;
    localparam int XSH_MIN = 10;
    localparam int QSH_MIN = 26;
    localparam logic [25:0] RCP_MS  = 26'((64'sd1 <<< (XSH_MS + QSH_MS)) / MS_PER_DAY);
    localparam logic [25:0] RCP_MIN = 26'((64'sd1 <<< (XSH_MIN + QSH_MIN)) / MIN_PER_DAY);

    // ms of day -> minutes (estimate, then one fix-up)
    localparam int RSH_MPM = 14;
    localparam int QSH_MPM = 20;
    localparam logic [18:0] RCP_MPM = 19'((64'sd1 <<< (RSH_MPM + QSH_MPM)) / MS_PER_MIN);

    // exact small-range divides (rounded-up reciprocals)
    localparam int HM_SH   = 19;
    localparam int HOUR_SH = 16;
    localparam int SEC_SH  = 26;
    localparam logic [12:0] RCP_HM   = 13'(((64'sd1 <<< HM_SH) + HM_SCALE - 1) / HM_SCALE);
    localparam logic [10:0] RCP_HOUR =
        11'(((64'sd1 <<< HOUR_SH) + MIN_PER_HOUR - 1) / MIN_PER_HOUR);
    localparam logic [16:0] RCP_SEC  = 17'(((64'sd1 <<< SEC_SH) + MS_PER_SEC - 1) / MS_PER_SEC);

    typedef struct packed {
        logic [11:0]        load_hour_minute;
        logic [2:0]         load_day;
        logic signed [31:0] amount;
    } in_item_t;

    typedef struct packed {
        logic        at_target;
        logic [9:0]  millisecond;
        logic [5:0]  second;
        logic [11:0] packed_hour_minute;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [2:0]  weekday;
    } result_t;

    // state-independent part of one update
    typedef struct packed {
        logic        load;
        logic [2:0]  day;
        logic [2:0]  dday;
        logic [11:0] add_min;
        logic [15:0] add_sub;
    } delta_t;

    // time of week: minute of day and ms within the minute
    typedef struct packed {
        logic [2:0]  day;
        logic [10:0] min;
        logic [15:0] sub;
    } tod_t;

endpackage

### rtl/core/wtra_delta.sv
`timescale 1ns / 1ps

module wtra_delta (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] amount,
    input  logic [2:0]         load_day,
    input  logic [11:0]        load_hour_minute,
    output logic               out_valid,
    input  logic               out_ready,
    output wtra_pkg::delta_t   delta
);

    logic [8:1] vld_reg;
    logic [8:1] rdy;

    logic [1:0]  op_reg [1:7];
    logic [2:0]  lday_reg [2:7];
    logic [11:0] lm_reg [3:7];
    logic [26:0] r_reg [5:7];
    logic [2:0]  dday_reg [6:7];
    logic [10:0] qm_reg [6:7];

    logic [31:0] amt1_reg;
    logic [2:0]  lday1_reg;
    logic [11:0] lhm1_reg;
    logic [32:0] x2_reg;
    logic [5:0]  hl2_reg;
    logic [11:0] lhm2_reg;
    logic [32:0] x3_reg;
    logic [22:0] qe3_reg;
    logic [22:0] qe4_reg;
    logic [27:0] r4_reg;
    logic [22:0] q5_reg;
    logic [16:0] sub7_reg;
    wtra_pkg::delta_t delta_reg;

    logic [31:0] a_flip;
    logic [32:0] x2_next;
    logic [24:0] hm_prod;
    logic [5:0]  hl2_next;
    logic [2:0]  lday2_next;
    logic [22:0] xt3;
    logic [25:0] rcp3;
    logic [48:0] qprod;
    logic [22:0] qe3_next;
    logic [11:0] lm3_next;
    logic [27:0] len3;
    logic [50:0] lprod;
    logic [27:0] r4_next;
    logic [27:0] len4;
    logic        ge4;
    logic [26:0] r5_next;
    logic [22:0] q5_next;
    logic [2:0]  m7;
    logic [3:0]  dsum;
    logic [2:0]  dday6_next;
    logic [31:0] mprod;
    logic [10:0] qm6_next;
    logic [16:0] sub7_next;
    logic        ge7;
    logic [15:0] sub_fix;
    logic [11:0] qm_fix;
    wtra_pkg::delta_t delta_next;

    // residue mod 7 by folding octal digits (8 = 1 mod 7)
    function automatic logic [2:0] mod7(input logic [22:0] v);
        logic [23:0] w;
        logic [5:0]  s;
        logic [3:0]  t;
        logic [2:0]  res;
        w = {1'b0, v};
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + 6'(w[3*i +: 3]);
        end
        t = 4'(s[5:3]) + 4'(s[2:0]);
        priority if (t >= 4'(2 * wtra_pkg::DAYS_WEEK))
            res = 3'(t - 4'(2 * wtra_pkg::DAYS_WEEK));
        else if (t >= 4'(wtra_pkg::DAYS_WEEK))
            res = 3'(t - 4'(wtra_pkg::DAYS_WEEK));
        else
            res = 3'(t);
        return res;
    endfunction

    always_comb
    begin
        rdy[8] = !vld_reg[8] || out_ready;
        for (int k = 7; k >= 1; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign in_ready  = rdy[1];
    assign out_valid = vld_reg[8];
    assign delta     = delta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            if (rdy[1]) begin
                vld_reg[1] <= in_valid;
            end
            for (int k = 2; k <= 8; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 2: rebias amount, split load time into hours
    always_comb
    begin
        a_flip     = {~amt1_reg[31], amt1_reg[30:0]};
        x2_next    = {1'b0, a_flip} +
                     ((op_reg[1] == wtra_pkg::OP_ADD_MIN) ? wtra_pkg::BIAS_MIN
                                                         : wtra_pkg::BIAS_MS);
        hm_prod    = 25'(lhm1_reg) * 25'(wtra_pkg::RCP_HM);
        hl2_next   = 6'(hm_prod >> wtra_pkg::HM_SH);
        lday2_next = (lday1_reg > 3'(wtra_pkg::DAY_MAX)) ? 3'd0 : lday1_reg;
    end

    // stage 3: day-count estimate, load minutes
    always_comb
    begin
        if (op_reg[2] == wtra_pkg::OP_ADD_MIN) begin
            xt3  = 23'(x2_reg >> wtra_pkg::XSH_MIN);
            rcp3 = wtra_pkg::RCP_MIN;
        end else begin
            xt3  = 23'(x2_reg >> wtra_pkg::XSH_MS);
            rcp3 = wtra_pkg::RCP_MS;
        end
        qprod = 49'(xt3) * 49'(rcp3);
        if (op_reg[2] == wtra_pkg::OP_ADD_MIN)
            qe3_next = 23'(qprod >> wtra_pkg::QSH_MIN);
        else
            qe3_next = 23'(qprod >> wtra_pkg::QSH_MS);
        lm3_next = lhm2_reg - 12'(hl2_reg) * 12'(wtra_pkg::HM_GAP);
    end

    // stage 4: remainder, lies in 0 .. 2*len-1
    always_comb
    begin
        len3    = (op_reg[3] == wtra_pkg::OP_ADD_MIN) ? 28'(wtra_pkg::MIN_PER_DAY)
                                                      : 28'(wtra_pkg::MS_PER_DAY);
        lprod   = 51'(qe3_reg) * 51'(len3);
        r4_next = 28'(x3_reg - 33'(lprod));
    end

    // stage 5: one fix-up
    always_comb
    begin
        len4    = (op_reg[4] == wtra_pkg::OP_ADD_MIN) ? 28'(wtra_pkg::MIN_PER_DAY)
                                                      : 28'(wtra_pkg::MS_PER_DAY);
        ge4     = (r4_reg >= len4);
        r5_next = 27'(ge4 ? (r4_reg - len4) : r4_reg);
        q5_next = qe4_reg + 23'(ge4);
    end

    // stage 6: weekday shift, minute estimate of the ms remainder
    always_comb
    begin
        m7   = mod7(q5_reg);
        dsum = 4'(m7) + ((op_reg[5] == wtra_pkg::OP_ADD_MIN) ? wtra_pkg::DAY_BACK_MIN
                                                             : wtra_pkg::DAY_BACK_MS);
        dday6_next = 3'((dsum >= 4'(wtra_pkg::DAYS_WEEK)) ?
                        (dsum - 4'(wtra_pkg::DAYS_WEEK)) : dsum);
        mprod    = 32'(r_reg[5] >> wtra_pkg::RSH_MPM) * 32'(wtra_pkg::RCP_MPM);
        qm6_next = 11'(mprod >> wtra_pkg::QSH_MPM);
    end

    // stage 7: ms within minute, lies in 0 .. 2*60000-1
    assign sub7_next = 17'(r_reg[6] - 27'(qm_reg[6]) * 27'(wtra_pkg::MS_PER_MIN));

    // stage 8: fix-up and build the delta
    always_comb
    begin
        ge7     = (sub7_reg >= 17'(wtra_pkg::MS_PER_MIN));
        sub_fix = 16'(ge7 ? (sub7_reg - 17'(wtra_pkg::MS_PER_MIN)) : sub7_reg);
        qm_fix  = 12'(qm_reg[7]) + 12'(ge7);
        delta_next = '0;
        unique case (op_reg[7])
            wtra_pkg::OP_LOAD:
            begin
                delta_next.load    = 1'b1;
                delta_next.day     = lday_reg[7];
                delta_next.add_min = lm_reg[7];
            end
            wtra_pkg::OP_ADD_MS:
            begin
                delta_next.dday    = dday_reg[7];
                delta_next.add_min = qm_fix;
                delta_next.add_sub = sub_fix;
            end
            wtra_pkg::OP_ADD_MIN:
            begin
                delta_next.dday    = dday_reg[7];
                delta_next.add_min = 12'(r_reg[7][10:0]);
            end
            default:
            begin
                delta_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1]) begin
            op_reg[1] <= opcode;
            amt1_reg  <= amount;
            lday1_reg <= load_day;
            lhm1_reg  <= load_hour_minute;
        end
        for (int k = 2; k <= 7; k++) begin
            if (rdy[k]) begin
                op_reg[k] <= op_reg[k-1];
            end
        end
        if (rdy[2]) begin
            x2_reg      <= x2_next;
            hl2_reg     <= hl2_next;
            lhm2_reg    <= lhm1_reg;
            lday_reg[2] <= lday2_next;
        end
        for (int k = 3; k <= 7; k++) begin
            if (rdy[k]) begin
                lday_reg[k] <= lday_reg[k-1];
            end
        end
        if (rdy[3]) begin
            x3_reg    <= x2_reg;
            qe3_reg   <= qe3_next;
            lm_reg[3] <= lm3_next;
        end
        for (int k = 4; k <= 7; k++) begin
            if (rdy[k]) begin
                lm_reg[k] <= lm_reg[k-1];
            end
        end
        if (rdy[4]) begin
            r4_reg  <= r4_next;
            qe4_reg <= qe3_reg;
        end
        if (rdy[5]) begin
            r_reg[5] <= r5_next;
            q5_reg   <= q5_next;
        end
        if (rdy[6]) begin
            r_reg[6]    <= r_reg[5];
            dday_reg[6] <= dday6_next;
            qm_reg[6]   <= qm6_next;
        end
        if (rdy[7]) begin
            r_reg[7]    <= r_reg[6];
            dday_reg[7] <= dday_reg[6];
            qm_reg[7]   <= qm_reg[6];
            sub7_reg    <= sub7_next;
        end
        if (rdy[8]) begin
            delta_reg <= delta_next;
        end
    end

endmodule

### rtl/core/wtra_state.sv
`timescale 1ns / 1ps

module wtra_state (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  wtra_pkg::delta_t delta,
    output logic             out_valid,
    input  logic             out_ready,
    output wtra_pkg::tod_t   tod
);

    logic           vld_reg;
    logic           rdy;
    wtra_pkg::tod_t tod_reg;
    wtra_pkg::tod_t tod_next;
    wtra_pkg::tod_t base;
    logic [16:0]    sub_sum;
    logic           c_sub;
    logic [11:0]    min_sum;
    logic           c_min;
    logic [3:0]     day_sum;

    assign rdy       = !vld_reg || out_ready;
    assign in_ready  = rdy;
    assign out_valid = vld_reg;
    assign tod       = tod_reg;

    always_comb
    begin
        if (delta.load) begin
            base.day = delta.day;
            base.min = '0;
            base.sub = '0;
        end else begin
            base = tod_reg;
        end
        sub_sum = 17'(base.sub) + 17'(delta.add_sub);
        c_sub   = (sub_sum >= 17'(wtra_pkg::MS_PER_MIN));
        tod_next.sub = 16'(c_sub ? (sub_sum - 17'(wtra_pkg::MS_PER_MIN)) : sub_sum);
        min_sum = 12'(base.min) + delta.add_min + 12'(c_sub);
        c_min   = (min_sum >= 12'(wtra_pkg::MIN_PER_DAY));
        tod_next.min = 11'(c_min ? (min_sum - 12'(wtra_pkg::MIN_PER_DAY)) : min_sum);
        day_sum = 4'(base.day) + 4'(delta.dday) + 4'(c_min);
        tod_next.day = 3'((day_sum >= 4'(wtra_pkg::DAYS_WEEK)) ?
                          (day_sum - 4'(wtra_pkg::DAYS_WEEK)) : day_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
            tod_reg <= '0;
        end else if (rdy) begin
            vld_reg <= in_valid;
            if (in_valid) begin
                tod_reg <= tod_next;
            end
        end
    end

endmodule

### rtl/core/wtra_fmt.sv
`timescale 1ns / 1ps

module wtra_fmt (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  wtra_pkg::tod_t    tod,
    input  logic [11:0]       target_hm,
    input  logic [10:0]       margin_minutes,
    output logic              out_valid,
    input  logic              out_ready,
    output wtra_pkg::result_t result
);

    logic [2:1] vld_reg;
    logic [2:1] rdy;

    logic [5:0]  tgt_h_reg;
    logic [11:0] tgt_min_reg;
    logic [24:0] tgt_prod;

    logic [2:0]  day1_reg;
    logic [10:0] min1_reg;
    logic [15:0] sub1_reg;
    logic [4:0]  h1_reg;
    logic [5:0]  sec1_reg;
    logic [21:0] h_prod;
    logic [32:0] s_prod;

    logic [11:0] diff;
    wtra_pkg::result_t res_reg;
    wtra_pkg::result_t res_next;

    assign rdy[2]    = !vld_reg[2] || out_ready;
    assign rdy[1]    = !vld_reg[1] || rdy[2];
    assign in_ready  = rdy[1];
    assign out_valid = vld_reg[2];
    assign result    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            if (rdy[1]) begin
                vld_reg[1] <= in_valid;
            end
            if (rdy[2]) begin
                vld_reg[2] <= vld_reg[1];
            end
        end
    end

    // target in minutes of day, via the tgt_h_reg then tgt_min_reg registers after a write
    assign tgt_prod = 25'(target_hm) * 25'(wtra_pkg::RCP_HM);

    always_ff @(posedge clk)
    begin
        tgt_h_reg   <= 6'(tgt_prod >> wtra_pkg::HM_SH);
        tgt_min_reg <= target_hm - 12'(tgt_h_reg) * 12'(wtra_pkg::HM_GAP);
    end

    assign h_prod = 22'(tod.min) * 22'(wtra_pkg::RCP_HOUR);
    assign s_prod = 33'(tod.sub) * 33'(wtra_pkg::RCP_SEC);

    always_comb
    begin
        res_next.weekday            = day1_reg;
        res_next.hour               = h1_reg;
        res_next.minute             =
            6'(min1_reg - 11'(h1_reg) * 11'(wtra_pkg::MIN_PER_HOUR));
        res_next.packed_hour_minute =
            12'(min1_reg) + 12'(h1_reg) * 12'(wtra_pkg::HM_GAP);
        res_next.second             = sec1_reg;
        res_next.millisecond        =
            10'(sub1_reg - 16'(sec1_reg) * 16'(wtra_pkg::MS_PER_SEC));
        diff = 12'(min1_reg) - tgt_min_reg;
        res_next.at_target = (12'(min1_reg) >= tgt_min_reg) &&
                             (diff <= 12'(margin_minutes));
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1]) begin
            day1_reg <= tod.day;
            min1_reg <= tod.min;
            sub1_reg <= tod.sub;
            h1_reg   <= 5'(h_prod >> wtra_pkg::HOUR_SH);
            sec1_reg <= 6'(s_prod >> wtra_pkg::SEC_SH);
        end
        if (rdy[2]) begin
            res_reg <= res_next;
        end
    end

endmodule

### rtl/core/weekly_time_register_adder_unit.sv
// Throughput: one beat per cycle while the output is ready; every stage holds
// one beat and moves on when the next stage is free, so bubbles close up under
// output stalls.
// The time state is one register, updated from a precomputed day/minute split.
// Reset: pipeline empty, time at Sunday 00:00:00.000, target and margin zero.
`timescale 1ns / 1ps

module weekly_time_register_adder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // amount, load_day, load_hour_minute
    input  logic [1:0]  s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // weekday, hour, minute, packed_hour_minute,
                                        // second, millisecond, at_target
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [11:0] cfg_wdata
);

    logic [11:0] target_reg;
    logic [10:0] margin_reg;

    wtra_pkg::in_item_t in_item;
    wtra_pkg::delta_t   delta;
    wtra_pkg::tod_t     tod;
    wtra_pkg::result_t  result;

    logic delta_valid;
    logic delta_ready;
    logic tod_valid;
    logic tod_ready;

    assign in_item = wtra_pkg::in_item_t'(s_axis_tdata[46:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            target_reg <= '0;
            margin_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                wtra_pkg::CFG_TARGET: target_reg <= cfg_wdata;
                wtra_pkg::CFG_MARGIN: margin_reg <= cfg_wdata[10:0];
                default:              target_reg <= target_reg;
            endcase
        end
    end

    wtra_delta u_delta (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_axis_tvalid),
        .in_ready         (s_axis_tready),
        .opcode           (s_axis_tuser),
        .amount           (in_item.amount),
        .load_day         (in_item.load_day),
        .load_hour_minute (in_item.load_hour_minute),
        .out_valid        (delta_valid),
        .out_ready        (delta_ready),
        .delta            (delta)
    );

    wtra_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (delta_valid),
        .in_ready  (delta_ready),
        .delta     (delta),
        .out_valid (tod_valid),
        .out_ready (tod_ready),
        .tod       (tod)
    );

    wtra_fmt u_fmt (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (tod_valid),
        .in_ready       (tod_ready),
        .tod            (tod),
        .target_hm      (target_reg),
        .margin_minutes (margin_reg),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .result         (result)
    );

    assign m_axis_tdata = {5'b0, result};

endmodule

### test/tb.sv
`timescale 1ns / 1ps

class week_clock_model;
    logic [11:0]       target_hm;
    logic [10:0]       margin_min;
    logic [2:0]        day;
    logic [11:0]       hm;
    logic [5:0]        sec;
    logic [9:0]        msec;
    wtra_pkg::result_t pending_times[$];
    int                errors;
    int                results_seen;
    int                beats_taken;
    int                op_count[4];

    function new();
        target_hm    = '0;
        margin_min   = '0;
        day          = '0;
        hm           = '0;
        sec          = '0;
        msec         = '0;
        errors       = 0;
        results_seen = 0;
        beats_taken  = 0;
        foreach (op_count[i]) op_count[i] = 0;
    endfunction

    function void set_reg(logic addr, logic [11:0] val);
        if (addr == wtra_pkg::CFG_TARGET)
            target_hm = val;
        else
            margin_min = val[10:0];
    endfunction

    function longint hm_to_minutes(logic [11:0] v);
        longint h;
        longint m;
        h = v / 100;
        m = v % 100;
        return h * 60 + m;
    endfunction

    // floor split over whole days; the quotient moves the weekday
    function longint roll_days(longint total, longint len);
        longint q;
        longint r;
        longint d;
        q = total / len;
        r = total % len;
        if (r < 0)
        begin
            r += len;
            q -= 1;
        end
        d = day;
        day = 3'((d + (q % 7) + 7) % 7);
        return r;
    endfunction

    function void set_minutes(longint mins);
        hm = 12'((mins / 60) * 100 + (mins % 60));
    endfunction

    function void take_beat(logic [1:0] op, wtra_pkg::in_item_t it);
        longint            amt;
        longint            rem;
        longint            total;
        longint            sec_l;
        longint            msec_l;
        longint            diff;
        longint            mg;
        wtra_pkg::result_t nxt;
        amt = $signed(it.amount);
        beats_taken++;
        op_count[op]++;
        case (op)
            wtra_pkg::OP_LOAD:
            begin
                day  = (it.load_day > 3'd6) ? 3'd0 : it.load_day;
                sec  = '0;
                msec = '0;
                rem  = roll_days(hm_to_minutes(it.load_hour_minute), wtra_pkg::MIN_PER_DAY);
                set_minutes(rem);
            end
            wtra_pkg::OP_ADD_MS:
            begin
                sec_l  = sec;
                msec_l = msec;
                total  = hm_to_minutes(hm) * wtra_pkg::MS_PER_MIN +
                         sec_l * wtra_pkg::MS_PER_SEC + msec_l + amt;
                rem    = roll_days(total, wtra_pkg::MS_PER_DAY);
                set_minutes(rem / wtra_pkg::MS_PER_MIN);
                sec  = 6'((rem / wtra_pkg::MS_PER_SEC) % 60);
                msec = 10'(rem % wtra_pkg::MS_PER_SEC);
            end
            wtra_pkg::OP_ADD_MIN:
            begin
                rem = roll_days(hm_to_minutes(hm) + amt, wtra_pkg::MIN_PER_DAY);
                set_minutes(rem);
            end
            default:
            begin
            end
        endcase
        mg   = margin_min;
        diff = hm_to_minutes(hm) - hm_to_minutes(target_hm);
        nxt.weekday            = day;
        nxt.hour               = 5'(hm / 100);
        nxt.minute             = 6'(hm % 100);
        nxt.packed_hour_minute = hm;
        nxt.second             = sec;
        nxt.millisecond        = msec;
        nxt.at_target          = (diff >= 0 && diff <= mg);
        pending_times.push_back(nxt);
    endfunction

    function void field_check(string name, logic [11:0] exp_v, logic [11:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
            errors++;
        end
    endfunction

    function void check_beat(wtra_pkg::result_t got);
        wtra_pkg::result_t exp_r;
        if (pending_times.size() == 0)
        begin
            $display("%0t: result beat with none expected, expected none got %h",
                     $time, got);
            errors++;
            return;
        end
        exp_r = pending_times.pop_front();
        results_seen++;
        field_check("weekday", exp_r.weekday, got.weekday);
        field_check("hour", exp_r.hour, got.hour);
        field_check("minute", exp_r.minute, got.minute);
        field_check("packed_hour_minute", exp_r.packed_hour_minute, got.packed_hour_minute);
        field_check("second", exp_r.second, got.second);
        field_check("millisecond", exp_r.millisecond, got.millisecond);
        field_check("at_target", exp_r.at_target, got.at_target);
    endfunction
endclass

module tb;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // amount, load_day, load_hour_minute
    logic [1:0]  s_axis_tuser = wtra_pkg::OP_LOAD;   // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // weekday, hour, minute, packed_hour_minute,
                                      // second, millisecond, at_target
    logic        cfg_we = 1'b0;
    logic        cfg_addr = wtra_pkg::CFG_TARGET;
    logic [11:0] cfg_wdata = '0;

    week_clock_model clock_model = new();

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;

    weekly_time_register_adder_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // output side: random stalls, or a long hold-off when requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            clock_model.check_beat(wtra_pkg::result_t'(m_axis_tdata[42:0]));
    end

    function automatic wtra_pkg::in_item_t make_item(logic [31:0] amt, logic [2:0] d,
                                                     logic [11:0] v);
        wtra_pkg::in_item_t it;
        it.amount           = amt;
        it.load_day         = d;
        it.load_hour_minute = v;
        return it;
    endfunction

    function automatic logic [31:0] rand_amount(int unsigned span);
        int unsigned sel;
        int unsigned mag;
        logic [31:0] v;
        sel = $urandom_range(99);
        if (sel < 60)
        begin
            mag = $urandom_range(span);
            v = $urandom_range(1) ? -mag : mag;
        end
        else if (sel < 90)
            v = $urandom;
        else if ($urandom_range(1))
            v = 32'h7FFF_FFFF - $urandom_range(3);
        else
            v = 32'h8000_0000 + $urandom_range(3);
        return v;
    endfunction

    function automatic void pick_random(output logic [1:0] op,
                                        output wtra_pkg::in_item_t it);
        int unsigned sel;
        logic [11:0] v;
        sel = $urandom_range(99);
        if ($urandom_range(99) < 85)
            v = 12'($urandom_range(23) * 100 + $urandom_range(59));
        else
            v = 12'($urandom);
        it = make_item($urandom, 3'($urandom_range(7)), v);
        if (sel < 15)
            op = wtra_pkg::OP_LOAD;
        else if (sel < 55)
        begin
            op = wtra_pkg::OP_ADD_MS;
            it.amount = rand_amount(259_200_000);
        end
        else if (sel < 90)
        begin
            op = wtra_pkg::OP_ADD_MIN;
            it.amount = rand_amount(20_000);
        end
        else
            op = wtra_pkg::OP_HOLD;
    endfunction

    task automatic send_beat(logic [1:0] op, wtra_pkg::in_item_t it);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, it};
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
        clock_model.take_beat(op, it);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (clock_model.pending_times.size() != 0)
            @(posedge clk);
        repeat (14) @(posedge clk);
    endtask

    task automatic write_config(logic [11:0] tgt, logic [10:0] mg);
        cfg_we    <= 1'b1;
        cfg_addr  <= wtra_pkg::CFG_TARGET;
        cfg_wdata <= tgt;
        @(posedge clk);
        clock_model.set_reg(wtra_pkg::CFG_TARGET, tgt);
        cfg_addr  <= wtra_pkg::CFG_MARGIN;
        cfg_wdata <= {1'b0, mg};
        @(posedge clk);
        clock_model.set_reg(wtra_pkg::CFG_MARGIN, {1'b0, mg});
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(int n, int snd_pct, int rcv_pct, bit pressure);
        logic [1:0]         op;
        wtra_pkg::in_item_t it;
        send_idle_pct = snd_pct;
        stall_pct     = rcv_pct;
        for (int i = 0; i < n; i++)
        begin
            if (pressure && i == 0)
                hold_left = 300;
            if (pressure && i == n / 2)
                wait_drain();
            pick_random(op, it);
            send_beat(op, it);
        end
        wait_drain();
    endtask

    function automatic logic [11:0] rand_target();
        return 12'($urandom_range(23) * 100 + $urandom_range(59));
    endfunction

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats, reset target and margin (midnight, zero)
        send_beat(wtra_pkg::OP_HOLD,    make_item(32'hFFFF_FFFF, 3'd7, 12'hFFF));
        send_beat(wtra_pkg::OP_LOAD,    make_item(32'd0, 3'd6, 12'd2359));
        send_beat(wtra_pkg::OP_ADD_MS,  make_item(32'd1, 3'd0, 12'd0));
        send_beat(wtra_pkg::OP_ADD_MS,  make_item(32'hFFFF_FFFF, 3'd0, 12'd0));
        send_beat(wtra_pkg::OP_ADD_MS,  make_item(32'h7FFF_FFFF, 3'd0, 12'd0));
        send_beat(wtra_pkg::OP_ADD_MS,  make_item(32'h8000_0000, 3'd0, 12'd0));
        send_beat(wtra_pkg::OP_LOAD,    make_item(32'hFFFF_FFFF, 3'd7, 12'd0));
        send_beat(wtra_pkg::OP_LOAD,    make_item(32'd0, 3'd1, 12'd2399));
        send_beat(wtra_pkg::OP_LOAD,    make_item(32'd0, 3'd3, 12'hFFF));
        send_beat(wtra_pkg::OP_ADD_MIN, make_item(32'h7FFF_FFFF, 3'd0, 12'd0));
        send_beat(wtra_pkg::OP_ADD_MIN, make_item(32'h8000_0000, 3'd0, 12'd0));
        send_beat(wtra_pkg::OP_ADD_MIN, make_item(32'hFFFF_FFFF, 3'd0, 12'd0));
        send_beat(wtra_pkg::OP_ADD_MIN, make_item(32'd10080, 3'd0, 12'd0));
        send_beat(wtra_pkg::OP_ADD_MS,  make_item(32'd86_400_000, 3'd0, 12'd0));
        send_beat(wtra_pkg::OP_ADD_MS,  make_item(-32'sd86_400_001, 3'd0, 12'd0));
        send_beat(wtra_pkg::OP_LOAD,    make_item(32'd0, 3'd0, 12'd0));
        send_beat(wtra_pkg::OP_ADD_MIN, make_item(32'd0, 3'd0, 12'd0));
        send_beat(wtra_pkg::OP_ADD_MS,  make_item(32'd999, 3'd0, 12'd0));
        send_beat(wtra_pkg::OP_ADD_MS,  make_item(32'd60_001, 3'd0, 12'd0));
        send_beat(wtra_pkg::OP_ADD_MIN, make_item(32'd61, 3'd4, 12'd1234));
        send_beat(wtra_pkg::OP_HOLD,    make_item(32'd0, 3'd0, 12'd0));
        wait_drain();

        write_config(12'd2359, 11'd1439);
        run_phase(240, 0, 0, 1'b0);
        write_config(12'hFFF, 11'd1439);
        run_phase(240, 56, 0, 1'b0);
        write_config(rand_target(), 11'd0);
        run_phase(240, 0, 56, 1'b0);
        write_config(rand_target(), 11'($urandom_range(1439)));
        run_phase(240, 38, 38, 1'b0);
        write_config(12'd0, 11'($urandom_range(1439)));
        run_phase(240, 0, 0, 1'b1);

        $display("Ran %0d input beats (load %0d, ms add %0d, minute add %0d, hold %0d),",
                 clock_model.beats_taken, clock_model.op_count[wtra_pkg::OP_LOAD],
                 clock_model.op_count[wtra_pkg::OP_ADD_MS],
                 clock_model.op_count[wtra_pkg::OP_ADD_MIN],
                 clock_model.op_count[wtra_pkg::OP_HOLD]);
        $display("%0d checked; six target/margin settings, four idle/stall mixes, %s",
                 clock_model.results_seen, "one long output hold-off");
        if (clock_model.errors == 0 && clock_model.pending_times.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
